// File: hw/rtl/ali_pkg.sv
`default_nettype none

package ali_pkg;

    localparam int CMD_W          = 3;
    localparam int POS_W          = 5;
    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 5;
    localparam int STATUS_W       = 2;
    localparam int DEFAULT_CAPACITY = 16;

    localparam logic [CMD_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] OP_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] OP_POP    = 3'd2;
    localparam logic [CMD_W-1:0] OP_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] OP_SET    = 3'd4;
    localparam logic [CMD_W-1:0] OP_GET    = 3'd5;
    localparam logic [CMD_W-1:0] OP_CLEAR  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_in;
    } ali_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [COUNT_W-1:0]       count;
        logic [STATUS_W-1:0]      status;
    } ali_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/ali_mem.sv
`default_nettype none

module ali_mem #(
    parameter int CAPACITY = ali_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0]   wr_addr,
    input  wire logic [ali_pkg::DATA_W-1:0]    wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(CAPACITY)-1:0]   rd_addr,
    output logic      [ali_pkg::DATA_W-1:0]    rd_data
);
    import ali_pkg::*;

    logic [DATA_W-1:0] store [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= store[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ali_seq.sv
`default_nettype none

module ali_seq #(
    parameter int CAPACITY = ali_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire ali_pkg::ali_cmd_t             cmd_data,
    output logic                               done,
    output ali_pkg::ali_rsp_t                  result,
    input  wire logic                          take,
    output logic                               mem_wr_en,
    output logic      [$clog2(CAPACITY)-1:0]   mem_wr_addr,
    output logic      [ali_pkg::DATA_W-1:0]    mem_wr_data,
    output logic                               mem_rd_en,
    output logic      [$clog2(CAPACITY)-1:0]   mem_rd_addr,
    input  wire logic [ali_pkg::DATA_W-1:0]    mem_rd_data
);
    import ali_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_WRITE = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic                ins_reg, ins_next;
    logic [DATA_W-1:0]   rdata_reg, rdata_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                accept;
    logic                full;
    logic                empty;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [IDX_W-1:0]    step;
    logic [IDX_W-1:0]    last_idx;

    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign cmd_stall = (state_reg != S_IDLE);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_ext   = CMP_W'(cmd_data.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));

    // Shared index unit: walks down for insert, up for erase
    assign step = ins_reg ? (idx_reg - IDX_W'(1)) : (idx_reg + IDX_W'(1));

    assign done             = (state_reg == S_DONE);
    assign result.read_data = rdata_reg;
    assign result.count     = COUNT_W'(count_reg);
    assign result.status    = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        ins_next    = ins_reg;
        rdata_next  = rdata_reg;
        status_next = status_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = val_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = step;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rdata_next  = '0;
                    status_next = ST_OK;
                    val_next    = cmd_data.data_in;
                    pos_next    = IDX_W'(cmd_data.position);
                    state_next  = S_DONE;
                    case (cmd_data.cmd)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = IDX_W'(count_reg);
                                mem_wr_data = cmd_data.data_in;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = IDX_W'(count_reg);
                                mem_wr_data = cmd_data.data_in;
                                count_next  = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ins_next   = 1'b1;
                                idx_next   = IDX_W'(count_reg);
                                state_next = S_READ;
                            end
                        end
                        OP_POP:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_ERASE, OP_SET, OP_GET:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_ext >= cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (cmd_data.cmd == OP_SET)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = IDX_W'(cmd_data.position);
                                mem_wr_data = cmd_data.data_in;
                            end
                            else if (cmd_data.cmd == OP_GET)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = IDX_W'(cmd_data.position);
                                state_next  = S_FETCH;
                            end
                            else if (IDX_W'(cmd_data.position) == last_idx)
                            begin
                                // erase of the last element needs no shift
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                ins_next   = 1'b0;
                                idx_next   = IDX_W'(cmd_data.position);
                                state_next = S_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (ins_reg && (idx_reg == pos_reg))
                begin
                    // hole reached: place the new value
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pos_reg;
                    mem_wr_data = val_reg;
                    count_next  = count_reg + CNT_W'(1);
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = step;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg;
                mem_wr_data = mem_rd_data;
                if (!ins_reg && (step == last_idx))
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = step;
                    state_next = S_READ;
                end
            end
            S_FETCH:
            begin
                rdata_next = mem_rd_data;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ins_reg    <= ins_next;
        rdata_reg  <= rdata_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/array_list_insert_erase_engine_top.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit words held in a single-port-write,
// single-port-read memory. One command transaction at a time: push, pop, set, clear
// and refused commands go straight to the result, a successful get reads first,
// insert at p below count shifts elements from p up before writing (insert at p
// equal to count appends directly), erase at p shifts the elements above p down;
// each shifted element costs one memory read and one write under the sequencer. A
// finished result sits in an output register, so the next command is accepted
// while it waits. Every command returns one result with read data, new count and status.
module array_list_insert_erase_engine_top #(
    parameter int CAPACITY = ali_pkg::DEFAULT_CAPACITY
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire ali_pkg::ali_cmd_t  cmd_data,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output ali_pkg::ali_rsp_t       rsp_data
);
    import ali_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    logic              done;
    logic              take;
    ali_rsp_t          result;
    logic              rsp_valid_reg, rsp_valid_next;
    ali_rsp_t          rsp_data_reg, rsp_data_next;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    ali_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_data    (cmd_data),
        .done        (done),
        .result      (result),
        .take        (take),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ali_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register is free when empty or being drained this cycle
    assign take = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (take)
        begin
            rsp_valid_next = done;
            if (done)
            begin
                rsp_data_next = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire
